### sv/lstm_layer_step_macros.svh
// ----------------------------------------------------------------------------
// LSTM layer step assertion macros
// Short forms for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef LSTM_LAYER_STEP_MACROS_SVH
`define LSTM_LAYER_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSTM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lstm_layer_step check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSTM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lstm_layer_step check failed");

`endif

### sv/lstm_pkg.sv
// ----------------------------------------------------------------------------
// LSTM layer step package
// Codes, fixed-point helpers, activation tables and controller interface types.
// ----------------------------------------------------------------------------
package lstm_pkg;

   // Request action codes.
   localparam logic [1:0] ACT_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_ELEM   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Source of the second multiplier operand for one accumulation term.
   localparam logic [1:0] SRC_BIAS = 2'd0;
   localparam logic [1:0] SRC_X    = 2'd1;
   localparam logic [1:0] SRC_H    = 2'd2;

   // Gate order inside the weight store.
   localparam logic [1:0] GATE_I = 2'd0;
   localparam logic [1:0] GATE_F = 2'd1;
   localparam logic [1:0] GATE_G = 2'd2;
   localparam logic [1:0] GATE_O = 2'd3;

   localparam int FRAC_BITS       = 12;
   localparam int ACT_TABLE_DEPTH = 256;
   localparam int ACT_IDX_W       = $clog2(ACT_TABLE_DEPTH);
   localparam int ACT_OFFSET      = 8 << FRAC_BITS;
   // The tables span 16 units, so one bin is a power of two wide.
   localparam int ACT_SHIFT       = FRAC_BITS + 4 - ACT_IDX_W;
   localparam int RND_W           = 48;
   localparam int HALF            = 1 << (FRAC_BITS - 1);
   localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

   typedef logic signed [15:0] act_rom_type [ACT_TABLE_DEPTH];

   typedef struct packed {
      logic       idle;
      logic       term;
      logic [1:0] src;
      logic       first;
      logic       last;
      logic       k_clr;
      logic       k_inc;
      logic       g_clr;
      logic       g_inc;
      logic       j_clr;
      logic       j_inc;
      logic       act_load;
      logic       cell_rd;
      logic       cell_mul;
      logic       cell_upd;
      logic       tanh_load;
      logic       h_mul;
      logic       h_wr;
      logic       out_rd;
      logic       out_load;
      logic       count_clr;
   } cmd_type;

   typedef struct packed {
      logic start;
      logic k_x_end;
      logic k_h_end;
      logic g_end;
      logic j_end;
      logic pre_rdy;
      logic rsp_free;
   } status_type;

   // Round half up at the binary point, then saturate to 16 bits.
   function automatic logic signed [15:0] round_sat(input logic signed [RND_W-1:0] v);
      logic signed [RND_W-1:0] s;
      s = (v + RND_W'(HALF)) >>> FRAC_BITS;
      if (s > RND_W'(32767)) begin
         return 16'sh7fff;
      end
      if (s < RND_W'(-32768)) begin
         return 16'sh8000;
      end
      return 16'(s);
   endfunction

   // Table index over [-8,8), clamped at both ends.
   function automatic logic [ACT_IDX_W-1:0] act_index(input logic signed [15:0] x);
      logic signed [39:0] off;
      logic signed [39:0] idx;
      off = 40'(x) + 40'(ACT_OFFSET);
      if (off < 0) begin
         return '0;
      end
      idx = off >>> ACT_SHIFT;
      if (idx > 40'(ACT_TABLE_DEPTH - 1)) begin
         return ACT_IDX_W'(ACT_TABLE_DEPTH - 1);
      end
      return ACT_IDX_W'(idx);
   endfunction

   // Unsigned shift-and-subtract quotient; elaboration only.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-a with a and the result in Q31; elaboration only.
   function automatic logic [63:0] exp_neg_q31(input logic [63:0] a);
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] r;
      t    = a >> 5;
      term = ONE_Q31;
      pos  = ONE_Q31;
      neg  = '0;
      for (int i = 1; i <= 20; i++) begin
         term = udiv64((term * t) >> 31, 64'(i));
         if (i[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      r = pos - neg;
      for (int n = 0; n < 5; n++) begin
         r = (r * r) >> 31;
      end
      return r;
   endfunction

   // Table entries hold the function at each bin midpoint; elaboration only.
   function automatic act_rom_type build_rom(input logic is_tanh);
      act_rom_type rom;
      int          s;
      logic        neg;
      logic [63:0] m;
      logic [63:0] a;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] v;
      for (int k = 0; k < ACT_TABLE_DEPTH; k++) begin
         s   = 2 * k + 1 - ACT_TABLE_DEPTH;
         neg = (s < 0);
         m   = 64'(neg ? -s : s);
         a   = ((64'd8 * m) << 31) >> ACT_IDX_W;
         if (!is_tanh) begin
            e      = exp_neg_q31(a);
            den    = ONE_Q31 + e;
            num    = neg ? e : ONE_Q31;
            rom[k] = 16'(udiv64((num << FRAC_BITS) + (den >> 1), den));
         end else begin
            e      = exp_neg_q31(a << 1);
            den    = ONE_Q31 + e;
            v      = udiv64(((ONE_Q31 - e) << FRAC_BITS) + (den >> 1), den);
            rom[k] = neg ? -16'(v) : 16'(v);
         end
      end
      return rom;
   endfunction

   localparam act_rom_type SIG_ROM  = build_rom(1'b0);
   localparam act_rom_type TANH_ROM = build_rom(1'b1);

endpackage

### sv/lstm_ram.sv
// ----------------------------------------------------------------------------
// LSTM generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lstm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lstm_ctrl.sv
// ----------------------------------------------------------------------------
// LSTM step controller
// Sequences accumulation, activation, cell update and result delivery.
// ----------------------------------------------------------------------------
module lstm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  lstm_pkg::status_type  status,
   output lstm_pkg::cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BIAS  = 4'd1;
   localparam logic [3:0] ST_XTERM = 4'd2;
   localparam logic [3:0] ST_HTERM = 4'd3;
   localparam logic [3:0] ST_DRAIN = 4'd4;
   localparam logic [3:0] ST_ACT   = 4'd5;
   localparam logic [3:0] ST_CMUL  = 4'd6;
   localparam logic [3:0] ST_CUPD  = 4'd7;
   localparam logic [3:0] ST_TANH  = 4'd8;
   localparam logic [3:0] ST_HMUL  = 4'd9;
   localparam logic [3:0] ST_HWR   = 4'd10;
   localparam logic [3:0] ST_ORD   = 4'd11;
   localparam logic [3:0] ST_OLD   = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (status.start) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_BIAS;
            end
         end
         ST_BIAS: begin
            cmd.term  = 1'b1;
            cmd.src   = lstm_pkg::SRC_BIAS;
            cmd.first = 1'b1;
            state_in  = ST_XTERM;
         end
         ST_XTERM: begin
            cmd.term = 1'b1;
            cmd.src  = lstm_pkg::SRC_X;
            if (status.k_x_end) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_HTERM;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         ST_HTERM: begin
            cmd.term = 1'b1;
            cmd.src  = lstm_pkg::SRC_H;
            if (status.k_h_end) begin
               cmd.last  = 1'b1;
               cmd.k_clr = 1'b1;
               state_in  = ST_DRAIN;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.pre_rdy) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            cmd.act_load = 1'b1;
            cmd.cell_rd  = 1'b1;
            if (status.g_end) begin
               cmd.g_clr = 1'b1;
               state_in  = ST_CMUL;
            end else begin
               cmd.g_inc = 1'b1;
               state_in  = ST_BIAS;
            end
         end
         ST_CMUL: begin
            cmd.cell_mul = 1'b1;
            state_in     = ST_CUPD;
         end
         ST_CUPD: begin
            cmd.cell_upd = 1'b1;
            state_in     = ST_TANH;
         end
         ST_TANH: begin
            cmd.tanh_load = 1'b1;
            state_in      = ST_HMUL;
         end
         ST_HMUL: begin
            cmd.h_mul = 1'b1;
            state_in  = ST_HWR;
         end
         ST_HWR: begin
            cmd.h_wr = 1'b1;
            if (status.j_end) begin
               cmd.j_clr = 1'b1;
               state_in  = ST_ORD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_BIAS;
            end
         end
         ST_ORD: begin
            if (status.rsp_free) begin
               cmd.out_rd = 1'b1;
               state_in   = ST_OLD;
            end
         end
         ST_OLD: begin
            cmd.out_load = 1'b1;
            if (status.j_end) begin
               cmd.j_clr     = 1'b1;
               cmd.count_clr = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_ORD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/lstm_dp.sv
// ----------------------------------------------------------------------------
// LSTM step datapath
// Weight and state memories, multiply-accumulate pipeline and cell arithmetic.
// ----------------------------------------------------------------------------
module lstm_dp #(
   parameter int IN_SIZE  = 8,
   parameter int HID_SIZE = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lstm_pkg::cmd_type        cmd,
   output lstm_pkg::status_type     status,
   input  logic                     req_valid,
   input  logic [1:0]               req_action,
   input  logic [13:0]              req_weight_address,
   input  logic signed [15:0]       req_weight_value,
   input  logic signed [15:0]       req_x_value,
   input  logic                     req_x_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_h_value,
   output logic [5:0]               rsp_h_index,
   output logic                     rsp_last_of_run
);

   localparam int GATE_WORDS   = IN_SIZE * HID_SIZE + HID_SIZE * HID_SIZE + HID_SIZE;
   localparam int WEIGHT_WORDS = 4 * GATE_WORDS;
   localparam int WAW          = $clog2(WEIGHT_WORDS);
   localparam int IW           = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
   localparam int HW           = (HID_SIZE > 1) ? $clog2(HID_SIZE) : 1;
   localparam int KW           = (IW > HW) ? IW : HW;
   localparam int CW           = $clog2(IN_SIZE + 1);
   localparam int ACC_W        = 32 + $clog2(IN_SIZE + HID_SIZE + 2);
   localparam int REC_BASE     = IN_SIZE * HID_SIZE;
   localparam int BIAS_BASE    = REC_BASE + HID_SIZE * HID_SIZE;

   logic accept;
   logic weight_wr;
   logic elem_wr;

   logic [KW-1:0] k_ff;
   logic [1:0]    g_ff;
   logic [HW-1:0] j_ff;
   logic [CW-1:0] count_ff;
   logic [HID_SIZE-1:0] hid_vld_ff;
   logic [HID_SIZE-1:0] cell_vld_ff;

   int            wa_int;
   logic [WAW-1:0] w_rd_addr;
   logic [15:0]   w_rd_data;
   logic [15:0]   x_rd_data;
   logic [15:0]   h_rd_data;
   logic [15:0]   c_rd_data;
   logic [15:0]   nh_rd_data;
   logic          op_ok;

   // Accumulation pipeline.
   logic          s1_vld_ff;
   logic [1:0]    s1_src_ff;
   logic          s1_first_ff;
   logic          s1_last_ff;
   logic          s1_ok_ff;
   logic signed [15:0] s1_op;
   logic signed [31:0] prod_in;
   logic signed [31:0] prod_ff;
   logic          s2_vld_ff;
   logic          s2_first_ff;
   logic          s2_last_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic          done_ff;
   logic signed [15:0] pre_ff;
   logic          pre_rdy_ff;

   // Gate and cell arithmetic.
   logic signed [15:0] gate_ff [4];
   logic signed [15:0] act_in;
   logic          cvld_ff;
   logic signed [15:0] c_old;
   logic signed [31:0] p_fc_ff;
   logic signed [31:0] p_ig_ff;
   logic signed [15:0] c_in;
   logic signed [15:0] c_ff;
   logic signed [15:0] tc_ff;
   logic signed [31:0] p_h_ff;
   logic signed [15:0] h_new;

   logic          rsp_valid_ff;
   logic signed [15:0] rsp_h_ff;
   logic [5:0]    rsp_idx_ff;
   logic          rsp_last_ff;

   assign accept    = req_valid && cmd.idle;
   assign weight_wr = accept && (req_action == lstm_pkg::ACT_WEIGHT) &&
                      (int'(req_weight_address) < WEIGHT_WORDS);
   assign elem_wr   = accept && (req_action == lstm_pkg::ACT_ELEM) &&
                      (int'(count_ff) < IN_SIZE);

   always_comb begin
      case (cmd.src)
         lstm_pkg::SRC_X: begin
            wa_int = IN_SIZE * int'(j_ff) + int'(k_ff);
            op_ok  = int'(k_ff) < int'(count_ff);
         end
         lstm_pkg::SRC_H: begin
            wa_int = REC_BASE + HID_SIZE * int'(j_ff) + int'(k_ff);
            op_ok  = hid_vld_ff[k_ff[HW-1:0]];
         end
         default: begin
            wa_int = BIAS_BASE + int'(j_ff);
            op_ok  = 1'b1;
         end
      endcase
   end

   assign w_rd_addr = WAW'(GATE_WORDS * int'(g_ff) + wa_int);

   lstm_ram #(.WIDTH(16), .DEPTH(WEIGHT_WORDS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (weight_wr),
      .wr_addr (WAW'(req_weight_address)),
      .wr_data (req_weight_value),
      .rd_en   (cmd.term),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   lstm_ram #(.WIDTH(16), .DEPTH(IN_SIZE)) u_input_ram (
      .clock   (clock),
      .wr_en   (elem_wr),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (req_x_value),
      .rd_en   (cmd.term),
      .rd_addr (k_ff[IW-1:0]),
      .rd_data (x_rd_data)
   );

   lstm_ram #(.WIDTH(16), .DEPTH(HID_SIZE)) u_hidden_ram (
      .clock   (clock),
      .wr_en   (cmd.out_load),
      .wr_addr (j_ff),
      .wr_data (nh_rd_data),
      .rd_en   (cmd.term),
      .rd_addr (k_ff[HW-1:0]),
      .rd_data (h_rd_data)
   );

   lstm_ram #(.WIDTH(16), .DEPTH(HID_SIZE)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cmd.cell_upd),
      .wr_addr (j_ff),
      .wr_data (c_in),
      .rd_en   (cmd.cell_rd),
      .rd_addr (j_ff),
      .rd_data (c_rd_data)
   );

   lstm_ram #(.WIDTH(16), .DEPTH(HID_SIZE)) u_new_hidden_ram (
      .clock   (clock),
      .wr_en   (cmd.h_wr),
      .wr_addr (j_ff),
      .wr_data (h_new),
      .rd_en   (cmd.out_rd),
      .rd_addr (j_ff),
      .rd_data (nh_rd_data)
   );

   // A bias term multiplies by one in fixed point.
   always_comb begin
      case (s1_src_ff)
         lstm_pkg::SRC_X: s1_op = s1_ok_ff ? $signed(x_rd_data) : 16'sd0;
         lstm_pkg::SRC_H: s1_op = s1_ok_ff ? $signed(h_rd_data) : 16'sd0;
         default:         s1_op = 16'sd1 <<< lstm_pkg::FRAC_BITS;
      endcase
   end

   assign prod_in = $signed(w_rd_data) * s1_op;

   always_comb begin
      if (g_ff == lstm_pkg::GATE_G) begin
         act_in = lstm_pkg::TANH_ROM[lstm_pkg::act_index(pre_ff)];
      end else begin
         act_in = lstm_pkg::SIG_ROM[lstm_pkg::act_index(pre_ff)];
      end
   end

   assign c_old = cvld_ff ? $signed(c_rd_data) : 16'sd0;
   assign c_in  = lstm_pkg::round_sat(lstm_pkg::RND_W'(p_fc_ff) +
                                      lstm_pkg::RND_W'(p_ig_ff));
   assign h_new = lstm_pkg::round_sat(lstm_pkg::RND_W'(p_h_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         g_ff         <= '0;
         j_ff         <= '0;
         count_ff     <= '0;
         hid_vld_ff   <= '0;
         cell_vld_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         done_ff      <= 1'b0;
         pre_rdy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.k_clr) begin
            k_ff <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.g_clr) begin
            g_ff <= '0;
         end else if (cmd.g_inc) begin
            g_ff <= g_ff + 1'b1;
         end
         if (cmd.j_clr) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.count_clr) begin
            count_ff <= '0;
         end else if (elem_wr) begin
            count_ff <= count_ff + 1'b1;
         end
         if (accept && (req_action == lstm_pkg::ACT_CLEAR)) begin
            hid_vld_ff  <= '0;
            cell_vld_ff <= '0;
         end else begin
            if (cmd.out_load) begin
               hid_vld_ff[j_ff] <= 1'b1;
            end
            if (cmd.cell_upd) begin
               cell_vld_ff[j_ff] <= 1'b1;
            end
         end
         s1_vld_ff  <= cmd.term;
         s2_vld_ff  <= s1_vld_ff;
         done_ff    <= s2_vld_ff && s2_last_ff;
         pre_rdy_ff <= done_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.term) begin
         s1_src_ff   <= cmd.src;
         s1_first_ff <= cmd.first;
         s1_last_ff  <= cmd.last;
         s1_ok_ff    <= op_ok;
      end
      if (s1_vld_ff) begin
         prod_ff     <= prod_in;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
      end
      if (s2_vld_ff) begin
         acc_ff <= s2_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
      if (done_ff) begin
         pre_ff <= lstm_pkg::round_sat(lstm_pkg::RND_W'(acc_ff));
      end
      if (cmd.act_load) begin
         gate_ff[g_ff] <= act_in;
      end
      if (cmd.cell_rd) begin
         cvld_ff <= cell_vld_ff[j_ff];
      end
      if (cmd.cell_mul) begin
         p_fc_ff <= gate_ff[lstm_pkg::GATE_F] * c_old;
         p_ig_ff <= gate_ff[lstm_pkg::GATE_I] * gate_ff[lstm_pkg::GATE_G];
      end
      if (cmd.cell_upd) begin
         c_ff <= c_in;
      end
      if (cmd.tanh_load) begin
         tc_ff <= lstm_pkg::TANH_ROM[lstm_pkg::act_index(c_ff)];
      end
      if (cmd.h_mul) begin
         p_h_ff <= gate_ff[lstm_pkg::GATE_O] * tc_ff;
      end
      if (cmd.out_load) begin
         rsp_h_ff    <= $signed(nh_rd_data);
         rsp_idx_ff  <= 6'(j_ff);
         rsp_last_ff <= status.j_end;
      end
   end

   assign status.start    = accept && (req_action == lstm_pkg::ACT_ELEM) && req_x_last;
   assign status.k_x_end  = int'(k_ff) == IN_SIZE - 1;
   assign status.k_h_end  = int'(k_ff) == HID_SIZE - 1;
   assign status.g_end    = g_ff == lstm_pkg::GATE_O;
   assign status.j_end    = int'(j_ff) == HID_SIZE - 1;
   assign status.pre_rdy  = pre_rdy_ff;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_h_value     = rsp_h_ff;
   assign rsp_h_index     = rsp_idx_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

### sv/lstm_layer_step.sv
// ----------------------------------------------------------------------------
// LSTM layer step
// One time step of an LSTM layer in signed Q4.12 fixed point.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ channel. A weight-write request stores one
// word, an element request appends one input value, and a clear request zeroes
// the hidden and cell state. Each of these is taken while idle.
// An element request with req_x_last set starts a step: req_stall stays high
// until every new hidden value has been moved into the output register.
// A step runs one multiply-accumulate per cycle through a single multiplier.
// Each gate of each hidden unit accumulates a bias, IN_SIZE input terms and
// HID_SIZE recurrent terms and is then activated; the cell and hidden update
// follow for each unit. The HID_SIZE results then leave on the rsp_ channel
// in index order, each read once the output register is free and then
// loaded into it, with rsp_last_of_run marking the final one.
// When the receiver holds rsp_stall, the result register keeps its value and
// the step waits; after the last result is loaded the block takes requests
// again even while that result is still waiting.
// Reset clears the hidden and cell state and the element count; weights hold
// whatever was last written and must be written before use.
// ----------------------------------------------------------------------------
module lstm_layer_step #(
   parameter int IN_SIZE  = 8,
   parameter int HID_SIZE = 50
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [13:0]        req_weight_address,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_x_value,
   input  logic               req_x_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_h_value,
   output logic [5:0]         rsp_h_index,
   output logic               rsp_last_of_run
);

   lstm_pkg::cmd_type    cmd;
   lstm_pkg::status_type status;

   // The controller owns sequencing only; all storage and arithmetic sit in
   // the datapath.
   lstm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lstm_dp #(.IN_SIZE(IN_SIZE), .HID_SIZE(HID_SIZE)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_valid          (req_valid),
      .req_action         (req_action),
      .req_weight_address (req_weight_address),
      .req_weight_value   (req_weight_value),
      .req_x_value        (req_x_value),
      .req_x_last         (req_x_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_h_value        (rsp_h_value),
      .rsp_h_index        (rsp_h_index),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // Requests are taken only while the sequencer is idle.
   assign req_stall = !cmd.idle;

endmodule

### sv/lstm_checker.sv
// ----------------------------------------------------------------------------
// LSTM layer step checker
// Port-level properties of the step engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "lstm_layer_step_macros.svh"

module lstm_checker #(
   parameter int HID_SIZE = 50
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_action,
   input logic               req_x_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_h_value,
   input logic [5:0]         rsp_h_index,
   input logic               rsp_last_of_run
);

   // A stalled result stays put.
   `LSTM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_h_value) && $stable(rsp_h_index) && $stable(rsp_last_of_run))

   // The final result of a step belongs to the last hidden unit.
   `LSTM_ASSERT_SAME(a_last_index, rsp_valid && rsp_last_of_run, rsp_h_index == 6'(HID_SIZE - 1))

   // A last element starts a step, so the next request must wait.
   `LSTM_ASSERT_NEXT(a_step_busy, req_valid && !req_stall && req_action == lstm_pkg::ACT_ELEM && req_x_last, req_stall)

   // Nothing follows the final result until a new step has run.
   `LSTM_ASSERT_NEXT(a_quiet_after_last, rsp_valid && !rsp_stall && rsp_last_of_run, !rsp_valid)

endmodule

bind lstm_layer_step lstm_checker #(.HID_SIZE(HID_SIZE)) u_lstm_checker (.*);

### bench/lstm_layer_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSTM layer step testbench
// Loads a full weight set, runs directed and random requests through the
// request channel with bursty traffic, and checks every new hidden value
// against a cycle-free fixed-point model of the layer step.
// ----------------------------------------------------------------------------
module lstm_layer_step_test;

   localparam int N_IN       = 8;
   localparam int N_HID      = 50;
   localparam int GATE_SPAN  = N_IN * N_HID + N_HID * N_HID + N_HID;
   localparam int WORDS      = 4 * GATE_SPAN;
   localparam int RAND_ITEMS = 300;
   // Room for a full step on every non-weight request under heavy stalls,
   // several times over.
   localparam int LIMIT      = 20000000;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   typedef struct {
      logic [1:0]         action;
      logic [13:0]        addr;
      logic signed [15:0] wval;
      logic signed [15:0] xval;
      logic               xlast;
      bit                 drain_first;   // hold this request until all results are back
   } request_type;

   typedef struct {
      logic signed [15:0] h;
      logic [5:0]         idx;
      logic               last;
   } hidden_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = lstm_pkg::ACT_WEIGHT;
   logic [13:0]        req_weight_address = '0;
   logic signed [15:0] req_weight_value = '0;
   logic signed [15:0] req_x_value = '0;
   logic               req_x_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_h_value;
   logic [5:0]         rsp_h_index;
   logic               rsp_last_of_run;

   lstm_layer_step uut (.*);

   always #5 clock = ~clock;

   // Model state: weights, recurrent state, the partial input vector and the
   // two activation tables.
   logic signed [15:0] wmem [WORDS];
   logic signed [15:0] hid_now [N_HID];
   logic signed [15:0] cell_now [N_HID];
   logic signed [15:0] xbuf [N_IN];
   int                 xcount;
   int                 sig_tab [256];
   int                 tanh_tab [256];

   request_type pending_requests [$];
   hidden_type  hidden_expected [$];
   int          mismatches = 0;
   int          steps_seen = 0;
   int          cycles = 0;

   // e^-a in Q31, a Taylor series on a/32 squared back up five times.
   function automatic logic [63:0] exp_q31(input logic [63:0] a);
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] p;
      logic [63:0] n;
      logic [63:0] r;
      t = a >> 5;
      term = 64'd1 << 31;
      p = 64'd1 << 31;
      n = 0;
      for (int i = 1; i <= 20; i++) begin
         term = ((term * t) >> 31) / 64'(i);
         if (i % 2 == 1) begin
            n += term;
         end else begin
            p += term;
         end
      end
      r = p - n;
      for (int i = 0; i < 5; i++) begin
         r = (r * r) >> 31;
      end
      return r;
   endfunction

   // Tables hold sigmoid and tanh at each bin midpoint of [-8,8).
   task automatic make_tables();
      longint      s;
      logic [63:0] a;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] v;
      for (int k = 0; k < 256; k++) begin
         s = 2 * k + 1 - 256;
         a = ((64'd8 * 64'(s < 0 ? -s : s)) << 31) / 64'd256;
         e = exp_q31(a);
         d = (64'd1 << 31) + e;
         v = (s < 0) ? e : (64'd1 << 31);
         sig_tab[k] = int'(((v << 12) + d / 2) / d);
         e = exp_q31(a << 1);
         d = (64'd1 << 31) + e;
         v = ((((64'd1 << 31) - e) << 12) + d / 2) / d;
         tanh_tab[k] = (s < 0) ? -int'(v) : int'(v);
      end
   endtask

   function automatic logic signed [15:0] q_round_sat(input longint v);
      longint r;
      r = (v + 2048) >>> 12;
      if (r > 32767) return 16'sh7fff;
      if (r < -32768) return 16'sh8000;
      return 16'(r);
   endfunction

   // Values at or above +8 land in the top bin, below -8 cannot occur in 16 bits.
   function automatic int bin_of(input logic signed [15:0] x);
      int b;
      b = (int'(x) + 32768) >> 8;
      return (b > 255) ? 255 : b;
   endfunction

   function automatic logic signed [15:0] preact(input int gate, input int j);
      int     base;
      longint acc;
      base = gate * GATE_SPAN;
      acc = longint'(wmem[base + N_IN * N_HID + N_HID * N_HID + j]) * 4096;
      for (int k = 0; k < N_IN; k++) begin
         acc += longint'(wmem[base + j * N_IN + k]) * longint'(xbuf[k]);
      end
      for (int k = 0; k < N_HID; k++) begin
         acc += longint'(wmem[base + N_IN * N_HID + j * N_HID + k]) * longint'(hid_now[k]);
      end
      return q_round_sat(acc);
   endfunction

   // One layer step: all gates read the old hidden vector, which is replaced
   // only once every unit has been updated.
   task automatic run_layer_step();
      logic signed [15:0] h_new [N_HID];
      longint             ig, fg, gg, og;
      hidden_type         r;
      for (int j = 0; j < N_HID; j++) begin
         ig = sig_tab[bin_of(preact(0, j))];
         fg = sig_tab[bin_of(preact(1, j))];
         gg = tanh_tab[bin_of(preact(2, j))];
         og = sig_tab[bin_of(preact(3, j))];
         cell_now[j] = q_round_sat(fg * longint'(cell_now[j]) + ig * gg);
         h_new[j] = q_round_sat(og * longint'(tanh_tab[bin_of(cell_now[j])]));
      end
      for (int j = 0; j < N_HID; j++) begin
         hid_now[j] = h_new[j];
         r.h = h_new[j];
         r.idx = 6'(j);
         r.last = (j == N_HID - 1);
         hidden_expected.push_back(r);
      end
      foreach (xbuf[k]) xbuf[k] = '0;
      xcount = 0;
   endtask

   task automatic apply_request(input request_type q);
      case (q.action)
         lstm_pkg::ACT_WEIGHT: begin
            if (q.addr < WORDS) wmem[q.addr] = q.wval;
         end
         lstm_pkg::ACT_ELEM: begin
            if (xcount < N_IN) begin
               xbuf[xcount] = q.xval;
               xcount++;
            end
            if (q.xlast) run_layer_step();
         end
         lstm_pkg::ACT_CLEAR: begin
            foreach (hid_now[k]) hid_now[k] = '0;
            foreach (cell_now[k]) cell_now[k] = '0;
         end
         default: ;
      endcase
   endtask

   // Request builders for the stimulus list.
   task automatic add_weight(input int addr, input int value);
      request_type q;
      q.action = lstm_pkg::ACT_WEIGHT;
      q.addr = 14'(addr);
      q.wval = 16'(value);
      q.xval = 16'($urandom);
      q.xlast = $urandom_range(0, 1);
      q.drain_first = 0;
      pending_requests.push_back(q);
   endtask

   task automatic add_elem(input int value, input bit last);
      request_type q;
      q.action = lstm_pkg::ACT_ELEM;
      q.addr = 14'($urandom);
      q.wval = 16'($urandom);
      q.xval = 16'(value);
      q.xlast = last;
      q.drain_first = 0;
      pending_requests.push_back(q);
   endtask

   task automatic add_other(input logic [1:0] action);
      request_type q;
      q.action = action;
      q.addr = 14'($urandom);
      q.wval = 16'($urandom);
      q.xval = 16'($urandom);
      q.xlast = $urandom_range(0, 1);
      q.drain_first = 0;
      pending_requests.push_back(q);
   endtask

   function automatic int small_value();
      return $urandom_range(0, 2047) - 1024;
   endfunction

   // Driver: bursts of requests separated by random gaps. The prediction is
   // made on the edge at which a request is taken, so the expectations are
   // always in place before the results can appear.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      request_type q;
      logic        next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request('{req_action, req_weight_address, req_weight_value,
                            req_x_value, req_x_last, 0});
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first && hidden_expected.size() > 0)) begin
               q = pending_requests.pop_front();
               next_valid = 1'b1;
               req_action <= q.action;
               req_weight_address <= q.addr;
               req_weight_value <= q.wval;
               req_x_value <= q.xval;
               req_x_last <= q.xlast;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  // About a third of the bursts run straight into the next one.
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: random stalls in phases, some of them free of stalls, plus one
   // long hold-off once a few steps have finished.
   int  hold_left = 0;
   int  phase_left = 0;
   int  stall_odds = 0;
   bit  long_hold_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && steps_seen >= 3 && rsp_valid) begin
         long_hold_done = 1;
         hold_left = 2000;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(16, 200);
            stall_odds = $urandom_range(0, 3);
         end
         phase_left--;
         rsp_stall <= (stall_odds != 0) && ($urandom_range(0, 3) < stall_odds);
      end
   end

   // Monitor: each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      hidden_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hidden_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: h=%0d index=%0d last=%0b",
                        rsp_h_value, rsp_h_index, rsp_last_of_run);
            end
         end else begin
            e = hidden_expected.pop_front();
            if (rsp_h_value !== e.h || rsp_h_index !== e.idx ||
                rsp_last_of_run !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: expected h=%0d index=%0d last=%0b, got h=%0d index=%0d last=%0b",
                           e.h, e.idx, e.last, rsp_h_value, rsp_h_index, rsp_last_of_run);
               end
            end
            if (e.last) steps_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      int pick;
      make_tables();
      foreach (wmem[k]) wmem[k] = '0;
      foreach (hid_now[k]) hid_now[k] = '0;
      foreach (cell_now[k]) cell_now[k] = '0;
      foreach (xbuf[k]) xbuf[k] = '0;
      xcount = 0;

      // Every weight word is written before the first step reads any of them.
      for (int a = 0; a < WORDS; a++) begin
         add_weight(a, small_value());
      end

      // Directed part.
      add_weight(WORDS - 1, 32767);           // top address, largest value
      add_weight(WORDS, -32768);              // first address past the store, ignored
      add_weight(16383, 32767);               // all address bits set, ignored
      add_other(ACT_SPARE);                   // unused action code
      add_elem(32767, 0);
      add_elem(-32768, 0);
      add_elem(0, 1);                         // short vector starts a step
      for (int k = 0; k < 10; k++) begin      // overlong vector, last two elements dropped
         add_elem(k[0] ? -32768 : 32767, k == 9);
      end
      add_weight(0, -32768);                  // push the first unit into saturation
      add_weight(GATE_SPAN + N_IN * N_HID + N_HID * N_HID, 32767);
      add_elem(12345, 0);
      add_other(lstm_pkg::ACT_CLEAR);         // clear in the middle of collection
      add_elem(-4000, 1);
      add_other(lstm_pkg::ACT_CLEAR);
      add_elem(1, 1);                         // step right after a clear

      // Random part: mostly well-formed input vectors with weight updates,
      // clears and ignored requests mixed in.
      n = 0;
      while (n < RAND_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if ($urandom_range(0, 9) == 0) begin
               add_weight($urandom_range(0, 16383), $urandom);
            end else begin
               add_weight($urandom_range(0, WORDS - 1),
                          $urandom_range(0, 3) == 0 ? int'($urandom) : small_value());
            end
         end else if (pick < 88) begin
            add_elem($urandom_range(0, 3) == 0 ? int'($urandom) : 2 * small_value(),
                     $urandom_range(0, 11) == 0);
         end else if (pick < 94) begin
            add_other(lstm_pkg::ACT_CLEAR);
         end else begin
            add_other(ACT_SPARE);
         end
         n++;
         if (n == RAND_ITEMS / 2) begin
            add_elem(small_value(), 1);
            add_elem(small_value(), 0);
            pending_requests[$].drain_first = 1;
         end
      end
      add_elem(small_value(), 1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
      while (hidden_expected.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
